/* design/rmtw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rmtw_pkg;

  // Fixed field and accumulator widths.
  localparam int TS_W     = 48;
  localparam int SAMPLE_W = 32;
  localparam int WSUM_W   = 64;
  localparam int CNT_W    = 32;

  // The sample magnitude is multiplied by the tick delta in two 24-bit halves.
  localparam int MUL_W    = 48;
  localparam int MUL_HALF = 24;
  localparam int PP_W     = SAMPLE_W + MUL_HALF;
  localparam int PROD_W   = SAMPLE_W + MUL_W;

  // The restoring divider produces one quotient bit per step.
  localparam int QUO_W    = 64;
  localparam int STEP_W   = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic dt_load;
    logic mul_lo;
    logic mul_hi;
    logic prod_sum;
    logic prod_sat;
    logic acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } rmtw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_tw;
    logic elapsed_nz;
    logic div_last;
    logic out_free;
  } rmtw_stat_t;

endpackage

`default_nettype wire

/* design/rmtw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmtw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   sample_missing,
  output logic                   in_ready,
  input  rmtw_pkg::rmtw_stat_t   stat,
  output rmtw_pkg::rmtw_cmd_t    cmd
);
  import rmtw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DT    = 4'd1;
  localparam logic [3:0] S_MLO   = 4'd2;
  localparam logic [3:0] S_MHI   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_SAT   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          if (stat.mode_tw) begin
            state_next = S_DT;
          end else if (!sample_missing) begin
            state_next = S_ACC;
          end
        end
      end
      S_DT: begin
        cmd.dt_load = 1'b1;
        state_next  = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.prod_sum = 1'b1;
        state_next   = S_SAT;
      end
      S_SAT: begin
        cmd.prod_sat = 1'b1;
        state_next   = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        // Time-weighted mode gives no result while no time has accumulated.
        if (!stat.mode_tw || stat.elapsed_nz) begin
          state_next = S_DINIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/rmtw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmtw_datapath #(
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmtw_pkg::rmtw_cmd_t                 cmd,
  output rmtw_pkg::rmtw_stat_t                stat,
  input  logic                                cfg_valid,
  input  logic                                cfg_data,
  input  logic [rmtw_pkg::TS_W-1:0]           timestamp,
  input  logic signed [rmtw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                sample_missing,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [rmtw_pkg::SAMPLE_W-1:0] mean_value
);
  import rmtw_pkg::*;

  localparam int DEN_W = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

  // Mode register and accumulated state.
  logic                  time_weighted;
  logic [CNT_W-1:0]      sample_count;
  logic [WSUM_W-1:0]     weighted_total;
  logic [TIME_BITS-1:0]  elapsed_total;
  logic [SAMPLE_W-1:0]   held_sample;
  logic                  held_missing;
  logic [TIME_BITS-1:0]  held_time;

  // Captured item and product pipeline.
  logic [TIME_BITS-1:0]  t_cap;
  logic [SAMPLE_W-1:0]   s_cap;
  logic                  held_cap_missing;
  logic [TIME_BITS-1:0]  dt;
  logic [SAMPLE_W-1:0]   mag;
  logic                  prod_neg;
  logic [PP_W-1:0]       pp_lo;
  logic [PP_W-1:0]       pp_hi;
  logic [PROD_W-1:0]     prod;
  logic [WSUM_W-1:0]     addend;

  // Divider registers.
  logic                  div_neg;
  logic [DEN_W-1:0]      den;
  logic [DEN_W-1:0]      rem;
  logic [QUO_W-1:0]      quo;
  logic [STEP_W-1:0]     step;

  // Combinational terms.
  logic [MUL_W-1:0]      dt_pad;
  logic [TIME_BITS:0]    el_sum;
  logic [PROD_W-1:0]     limit;
  logic [WSUM_W-1:0]     prod_mag;
  logic [WSUM_W-1:0]     acc_in;
  logic [WSUM_W:0]       acc_sum;
  logic [WSUM_W-1:0]     acc_sat;
  logic [WSUM_W-1:0]     wt_mag;
  logic [DEN_W:0]        shifted;
  logic [DEN_W:0]        diff;
  logic                  quo_big;
  logic [SAMPLE_W-1:0]   mean_next;

  assign dt_pad = MUL_W'(dt);

  // Saturating add of the tick delta to the elapsed total.
  assign el_sum = {1'b0, elapsed_total} + {1'b0, dt};

  // Product magnitude is clamped to 2^63 for a negative sample, 2^63-1 otherwise.
  assign limit    = {{(PROD_W - WSUM_W){1'b0}}, prod_neg, {(WSUM_W - 1){~prod_neg}}};
  assign prod_mag = (prod > limit) ? limit[WSUM_W-1:0] : prod[WSUM_W-1:0];

  // Accumulator adder with signed saturation.
  assign acc_in  = time_weighted ? addend
                                 : {{(WSUM_W - SAMPLE_W){s_cap[SAMPLE_W-1]}}, s_cap};
  assign acc_sum = {weighted_total[WSUM_W-1], weighted_total} + {acc_in[WSUM_W-1], acc_in};
  always_comb begin
    if (acc_sum[WSUM_W] != acc_sum[WSUM_W-1]) begin
      acc_sat = {acc_sum[WSUM_W], {(WSUM_W - 1){~acc_sum[WSUM_W]}}};
    end else begin
      acc_sat = acc_sum[WSUM_W-1:0];
    end
  end

  // Dividend magnitude; the most negative total maps to 2^63.
  assign wt_mag = weighted_total[WSUM_W-1] ? (~weighted_total + 1'b1) : weighted_total;

  // One restoring division step.
  assign shifted = {rem, quo[QUO_W-1]};
  assign diff    = shifted - {1'b0, den};

  // Signed result, truncated toward zero and saturated to 32 bits.
  assign quo_big = |quo[QUO_W-1:SAMPLE_W-1];
  always_comb begin
    if (div_neg) begin
      mean_next = quo_big ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : (~quo[SAMPLE_W-1:0] + 1'b1);
    end else begin
      mean_next = quo_big ? {1'b0, {(SAMPLE_W - 1){1'b1}}} : quo[SAMPLE_W-1:0];
    end
  end

  assign stat.mode_tw    = time_weighted;
  assign stat.elapsed_nz = |elapsed_total;
  assign stat.div_last   = (step == '0);
  assign stat.out_free   = !out_valid || out_ready;

  // Mode register, accumulators, held sample and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_weighted  <= 1'b0;
      sample_count   <= '0;
      weighted_total <= '0;
      elapsed_total  <= '0;
      held_sample    <= '0;
      held_missing   <= 1'b1;
      held_time      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_weighted <= cfg_data;
      end
      if (cmd.dt_load) begin
        held_sample  <= s_cap;
        held_missing <= held_cap_missing;
        held_time    <= t_cap;
      end
      if (cmd.mul_lo) begin
        elapsed_total <= el_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : el_sum[TIME_BITS-1:0];
      end
      if (cmd.acc) begin
        weighted_total <= acc_sat;
        if (!time_weighted && (sample_count != {CNT_W{1'b1}})) begin
          sample_count <= sample_count + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: captured item, product pipeline, divider, result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_cap            <= timestamp[TIME_BITS-1:0];
      s_cap            <= sample;
      held_cap_missing <= sample_missing;
    end
    if (cmd.dt_load) begin
      // Nothing held, or time going backwards, contributes no ticks.
      if (held_missing || (t_cap < held_time)) begin
        dt <= '0;
      end else begin
        dt <= t_cap - held_time;
      end
      prod_neg <= held_sample[SAMPLE_W-1];
      mag      <= held_sample[SAMPLE_W-1] ? (~held_sample + 1'b1) : held_sample;
    end
    if (cmd.mul_lo) begin
      pp_lo <= PP_W'(mag) * PP_W'(dt_pad[MUL_HALF-1:0]);
    end
    if (cmd.mul_hi) begin
      pp_hi <= PP_W'(mag) * PP_W'(dt_pad[MUL_W-1:MUL_HALF]);
    end
    if (cmd.prod_sum) begin
      prod <= PROD_W'(pp_lo) + {pp_hi, {MUL_HALF{1'b0}}};
    end
    if (cmd.prod_sat) begin
      addend <= prod_neg ? (~prod_mag + 1'b1) : prod_mag;
    end
    if (cmd.div_init) begin
      div_neg <= weighted_total[WSUM_W-1];
      quo     <= wt_mag;
      rem     <= '0;
      den     <= time_weighted ? DEN_W'(elapsed_total) : DEN_W'(sample_count);
      step    <= STEP_W'(QUO_W - 1);
    end
    if (cmd.div_step) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      step <= step - 1'b1;
    end
    if (cmd.out_load) begin
      mean_value <= mean_next;
    end
  end

endmodule

`default_nettype wire

/* design/running_mean_time_weighted_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Running mean of signed Q16.16 samples, plain or time-weighted (sample-hold).
// Each accepted item yields at most one mean_value transfer, after the
// accumulator update and the 64-step restoring divider; time-weighted mode
// first adds a two-pass 32x24 multiply of the held sample by its tick delta.
// A missing sample in plain mode produces no result and frees the input at
// once; a time-weighted item while no time has yet accumulated produces no
// result and frees the input after its update. One item is worked on at a
// time; the next is taken while a finished result still waits in the output
// register, and that next result then waits in its final cycle until the
// output register is free. The mode register is written through the cfg
// channel, which is always ready and must only be used while the block is
// idle.
module running_mean_time_weighted_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rmtw_pkg::TS_W-1:0]           timestamp,
  input  logic signed [rmtw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                sample_missing,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rmtw_pkg::SAMPLE_W-1:0] mean_value
);
  import rmtw_pkg::*;

  rmtw_cmd_t  cmd;
  rmtw_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  rmtw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .sample_missing (sample_missing),
    .in_ready       (in_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Accumulators, multiplier, divider and output register.
  rmtw_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .timestamp      (timestamp),
    .sample         (sample),
    .sample_missing (sample_missing),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .mean_value     (mean_value)
  );

endmodule

`default_nettype wire

/* design/rmtw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmtw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic                                cfg_data,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [rmtw_pkg::TS_W-1:0]           timestamp,
  input logic signed [rmtw_pkg::SAMPLE_W-1:0] sample,
  input logic                                sample_missing,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rmtw_pkg::SAMPLE_W-1:0] mean_value
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_value))
    else $error("mean_value changed or dropped while stalled");

  // A new result is only loaded while the input side is busy.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input was ready");

  // No result can follow an input transfer in the very next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too soon after input transfer");

  // Reset leaves the output channel empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind running_mean_time_weighted_unit rmtw_checker u_rmtw_checker (.*);

`default_nettype wire

/* bench/running_mean_checker.sv */
`timescale 1ns / 1ps

module running_mean_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic                                 cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [rmtw_pkg::TS_W-1:0]            timestamp,
  input  logic signed [rmtw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 sample_missing,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [rmtw_pkg::SAMPLE_W-1:0] mean_value,
  output int                                   mismatch_count,
  output int                                   pending_count
);

  localparam logic signed [rmtw_pkg::WSUM_W-1:0] WSUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [rmtw_pkg::WSUM_W-1:0] WSUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [81:0] PROD_MAX = 82'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [81:0] PROD_MIN = -PROD_MAX - 82'sd1;
  localparam logic [rmtw_pkg::TS_W-1:0] TICK_MAX = '1;
  localparam int REPORT_LIMIT = 10;

  // Private copy of the mode register and the accumulator state.
  logic                                 tw_mode;
  logic [rmtw_pkg::CNT_W-1:0]           sample_cnt;
  logic signed [rmtw_pkg::WSUM_W-1:0]   wsum;
  logic [rmtw_pkg::TS_W-1:0]            elapsed;
  logic signed [rmtw_pkg::SAMPLE_W-1:0] held_val;
  logic                                 held_absent;
  logic [rmtw_pkg::TS_W-1:0]            held_ts;

  logic [rmtw_pkg::SAMPLE_W-1:0] expected_means[$];
  int errors;

  // Signed 64-bit add that clamps at both limits.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) return sum[64] ? WSUM_MIN : WSUM_MAX;
    return sum[63:0];
  endfunction

  // Quotient truncated toward zero, clamped to the signed 32-bit range.
  function automatic logic [31:0] sat_div32(input logic signed [63:0] num,
                                            input logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = num[63] ? (~num + 64'd1) : num;
    quo = mag / den;
    if (num[63]) begin
      if (quo >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - quo[31:0];
    end
    if (quo > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  // Advances the mean state by one sample; returns 1 when a mean is produced.
  function automatic bit predict_mean(input logic [rmtw_pkg::TS_W-1:0] ts,
                                      input logic signed [31:0] val,
                                      input logic absent,
                                      output logic [31:0] mean);
    logic [rmtw_pkg::TS_W-1:0] dt;
    logic [rmtw_pkg::TS_W-1:0] room;
    logic signed [81:0] prod;
    logic signed [63:0] weight;
    if (!tw_mode) begin
      // Plain mean: missing samples leave everything untouched.
      if (absent) return 1'b0;
      if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;
      wsum = sat_add64(wsum, {{32{val[31]}}, val});
      mean = sat_div32(wsum, {32'd0, sample_cnt});
      return 1'b1;
    end
    // Time-weighted mean: the held sample covers the interval up to now.
    if (!held_absent) begin
      dt = (ts >= held_ts) ? ts - held_ts : '0;
      room = TICK_MAX - elapsed;
      elapsed = (dt > room) ? TICK_MAX : elapsed + dt;
      prod = $signed({{50{held_val[31]}}, held_val}) * $signed({34'd0, dt});
      if (prod > PROD_MAX) weight = WSUM_MAX;
      else if (prod < PROD_MIN) weight = WSUM_MIN;
      else weight = prod[63:0];
      wsum = sat_add64(wsum, weight);
    end
    held_ts = ts;
    held_val = val;
    held_absent = absent;
    if (elapsed == '0) return 1'b0;
    mean = sat_div32(wsum, {16'd0, elapsed});
    return 1'b1;
  endfunction

  // Watch all three channels, predict on each input transfer and compare
  // each result transfer with the oldest prediction.
  always @(posedge clk) begin : watch
    logic [31:0] predicted;
    logic [31:0] oldest;
    if (rst) begin
      tw_mode = 1'b0;
      sample_cnt = '0;
      wsum = '0;
      elapsed = '0;
      held_val = '0;
      held_absent = 1'b1;
      held_ts = '0;
      expected_means.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) tw_mode = cfg_data;
      if (in_valid && in_ready) begin
        if (predict_mean(timestamp, sample, sample_missing, predicted))
          expected_means.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected mean_value transfer 0x%08h", $time, mean_value);
        end else begin
          oldest = expected_means.pop_front();
          if (mean_value !== oldest) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: mean_value mismatch, expected 0x%08h, got 0x%08h",
                       $time, oldest, mean_value);
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_count <= expected_means.size();
  end

endmodule

/* bench/tb_running_mean_time_weighted_unit.sv */
`timescale 1ns / 1ps

module tb_running_mean_time_weighted_unit;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int RANDOM_PHASES = 6;
  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_TIME = 1'b1;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [47:0] T_MAX = '1;

  logic                                 clk;
  logic                                 rst = 1'b1;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic                                 cfg_data = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [rmtw_pkg::TS_W-1:0]            timestamp = '0;
  logic signed [rmtw_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                 sample_missing = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [rmtw_pkg::SAMPLE_W-1:0] mean_value;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int burst_left = 0;
  logic [47:0] cur_ts = '0;

  running_mean_time_weighted_unit #(
    .TIME_BITS(48)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .timestamp(timestamp),
    .sample(sample),
    .sample_missing(sample_missing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mean_value(mean_value)
  );

  running_mean_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .timestamp(timestamp),
    .sample(sample),
    .sample_missing(sample_missing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mean_value(mean_value),
    .mismatch_count(mismatch_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_running_mean_time_weighted_unit: FAIL");
      $finish;
    end
  end

  // Offers one sample and returns at the edge of its transfer. Items come in
  // bursts of random length with random gaps between bursts.
  task automatic send_item(input logic [47:0] ts, input logic [31:0] val,
                           input logic absent);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    timestamp <= ts;
    sample <= val;
    sample_missing <= absent;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits for the block to drain and settle, then writes the mode register.
  task automatic write_mode(input logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random sample. In time-weighted mode time mostly moves forward in
  // modest steps; after a missing sample it may jump anywhere, since a
  // missing sample stops the held interval from counting.
  task automatic random_item(input logic tw);
    logic [31:0] val;
    logic [63:0] wide;
    logic absent;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) val = S_MAX;
    else if (pick == 1) val = S_MIN;
    else if (pick < 5) val = $urandom_range(0, 32'h3FFFF) - 32'h20000;
    else val = $urandom;
    absent = ($urandom_range(0, 7) == 0);
    wide = {$urandom, $urandom};
    if (!tw) begin
      send_item(wide[47:0], val, absent);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) cur_ts = cur_ts + 48'($urandom_range(1, 255));
      else if (pick < 85) cur_ts = cur_ts + 48'($urandom_range(256, 65535));
      else if (pick >= 92 && cur_ts > 48'd300) cur_ts = cur_ts - 48'($urandom_range(1, 300));
      send_item(cur_ts, val, absent);
      if (absent && $urandom_range(0, 1) == 1) cur_ts = wide[47:0];
    end
  endtask

  // Receiver: segments of different ready patterns, with one long hold-off
  // so that the block fills up and stalls its input.
  initial begin : receiver
    int seg;
    int kind;
    int len;
    int i;
    seg = 0;
    forever begin
      if (seg == 12) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 3);
        len = $urandom_range(40, 400);
        for (i = 0; i < len; i++) begin
          case (kind)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 5) == 0);
            default: out_ready <= ((i % 7) < 3);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  initial begin : stimulus
    int phase;
    int k;
    logic tw;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Plain mean: field extremes and a missing sample.
    write_mode(MODE_PLAIN);
    send_item(T_MAX, S_MAX, 1'b0);
    send_item('0, S_MIN, 1'b0);
    send_item('0, '0, 1'b0);
    send_item(T_MAX, 32'h1234_5678, 1'b1);
    send_item(48'h5555_5555_5555, 32'hFFFF_FFFF, 1'b0);
    send_item(48'hAAAA_AAAA_AAAA, 32'h0001_0000, 1'b0);

    // Time-weighted mean: nothing held yet, zero elapsed time, time going
    // backwards, and a held missing sample.
    write_mode(MODE_TIME);
    send_item(48'd100, 32'h0002_0000, 1'b0);
    send_item(48'd100, 32'h0003_0000, 1'b0);
    send_item(48'd110, 32'hFFFF_0000, 1'b0);
    send_item(48'd90, 32'd5, 1'b0);
    send_item(48'd120, '0, 1'b1);
    send_item(48'd1000, 32'd7, 1'b0);
    send_item(48'd1010, S_MAX, 1'b0);
    send_item(48'd1011, S_MIN, 1'b0);
    send_item(48'd1020, '0, 1'b0);
    cur_ts = 48'd1020;

    // Random phases alternate between the two modes.
    tw = MODE_PLAIN;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_mode(tw);
      repeat (ITEMS_PER_PHASE) random_item(tw);
      tw = ~tw;
    end

    // Saturation: huge negative weights drive the sum to its lower limit and
    // the elapsed total to its upper limit; then the plain mean clamps.
    write_mode(MODE_TIME);
    for (k = 0; k < 2; k++) begin
      send_item(cur_ts, '0, 1'b1);
      send_item('0, S_MIN, 1'b0);
      send_item(T_MAX, '0, 1'b0);
      cur_ts = T_MAX;
    end
    write_mode(MODE_PLAIN);
    send_item(T_MAX, S_MIN, 1'b0);

    // The same toward the upper limit.
    write_mode(MODE_TIME);
    for (k = 0; k < 3; k++) begin
      send_item(cur_ts, '0, 1'b1);
      send_item('0, S_MAX, 1'b0);
      send_item(T_MAX, '0, 1'b0);
    end
    write_mode(MODE_PLAIN);
    send_item('0, S_MAX, 1'b0);

    // Drain and settle, then report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_running_mean_time_weighted_unit: PASS");
    end else begin
      $display("tb_running_mean_time_weighted_unit: FAIL");
    end
    $finish;
  end

endmodule
